FILE: rtl/core/rcfr_pkg.sv
// Package for the remote-control frame receiver: result word layout,
// result kind codes, register indexes and the resolution mask helper.
// No dependencies.
`default_nettype none

package rcfr_pkg;

	// Configuration port layout.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;
	localparam logic [7:0] START_MARKER_RESET = 8'd201;
	localparam logic [7:0] END_MARKER_RESET   = 8'd147;

	// Result kind codes.
	localparam logic [1:0] KIND_CHAN      = 2'd0;
	localparam logic [1:0] KIND_FRAME_OK  = 2'd1;
	localparam logic [1:0] KIND_FRAME_BAD = 2'd2;

	// One result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic        last;
		logic [7:0]  channel_index;
		logic [11:0] channel_value;
		logic        checksum_ok;
		logic [7:0]  sequence_id;
		logic [7:0]  sender_id;
		logic [3:0]  resolution_bits;
		logic [8:0]  channel_count;
		logic [3:0]  routing_length;
		logic [1:0]  discover_state;
		logic [7:0]  error_count;
	} result_t;

	// Results produced by the parser for one byte: up to two words.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} parse_out_t;

	// Low-bit mask for a channel of the given resolution.
	function automatic logic [11:0] res_mask(input logic [3:0] bits);
		logic [12:0] one_hot;
		one_hot = 13'd1 << bits;
		return 12'(one_hot - 13'd1);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rcfr_if.sv
// Handshake interfaces for the frame receiver: the byte input channel and
// the result output channel. No dependencies.
`default_nettype none

interface rcfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface rcfr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        last;
	logic [7:0]  channel_index;
	logic [11:0] channel_value;
	logic        checksum_ok;
	logic [7:0]  sequence_id;
	logic [7:0]  sender_id;
	logic [3:0]  resolution_bits;
	logic [8:0]  channel_count;
	logic [3:0]  routing_length;
	logic [1:0]  discover_state;
	logic [7:0]  error_count;

	modport source (output valid, output kind, output last, output channel_index,
		output channel_value, output checksum_ok, output sequence_id, output sender_id,
		output resolution_bits, output channel_count, output routing_length,
		output discover_state, output error_count, input ready);
	modport sink (input valid, input kind, input last, input channel_index,
		input channel_value, input checksum_ok, input sequence_id, input sender_id,
		input resolution_bits, input channel_count, input routing_length,
		input discover_state, input error_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rcfr_parser.sv
// Frame parser: packet phase tracking, header capture, channel bit
// assembly, checksum and error score. Depends on rcfr_pkg.
`default_nettype none

module rcfr_parser
	import rcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] start_marker,
	input  wire logic [7:0] end_marker,
	output parse_out_t      res
);

	typedef enum logic [2:0] {
		PH_WAIT, PH_SEQ, PH_SENDER, PH_CONFIG, PH_MESH, PH_DATA, PH_CHECK, PH_END
	} phase_t;

	localparam logic [1:0] DISC_MSG = 2'd1;
	localparam logic [2:0] CKEY_MAX = 3'b111;

	phase_t      ph_q, ph_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  sender_q, sender_d;
	logic [3:0]  resb_q, resb_d;
	logic [8:0]  ccount_q, ccount_d;
	logic [3:0]  route_q, route_d;
	logic [1:0]  disc_q, disc_d;
	logic [8:0]  bleft_q, bleft_d;
	logic [7:0]  xor_q, xor_d;
	logic        chk_q, chk_d;
	logic [11:0] asm_q, asm_d;
	logic [3:0]  pos_q, pos_d;
	logic [8:0]  ptr_q, ptr_d;
	logic [7:0]  score_q, score_d;

	// Bit assembly terms for the current byte.
	logic [11:0] mask;
	logic [3:0]  need1;
	logic        c1, c2, e1, e2;
	logic [19:0] wide;
	logic [11:0] val1, val2;
	logic [7:0]  rest, rest2;
	logic [3:0]  rem;
	logic [8:0]  ptr1, ptr2;

	always_comb begin
		mask  = res_mask(resb_q);
		need1 = resb_q - pos_q;
		c1    = (need1 <= 4'd8);
		wide  = ({12'b0, data_byte} << pos_q) | {8'b0, asm_q};
		val1  = wide[11:0] & mask;
		rest  = data_byte >> need1;
		rem   = 4'd8 - need1;
		c2    = c1 && (rem >= resb_q);
		val2  = {4'b0, rest} & mask;
		rest2 = rest >> resb_q;
		e1    = c1 && (ptr_q < ccount_q);
		ptr1  = ptr_q + {8'b0, e1};
		e2    = c2 && (ptr1 < ccount_q);
		ptr2  = ptr1 + {8'b0, e2};
	end

	// Header decode terms for a configuration byte.
	logic [3:0]  cfg_res;
	logic [3:0]  cfg_shift;
	logic [11:0] cfg_prod;
	logic [12:0] cfg_sum;

	always_comb begin
		cfg_res   = 4'd5 + {1'b0, data_byte[2:0]};
		cfg_shift = (data_byte[5:3] == CKEY_MAX) ? 4'd8 : {1'b0, data_byte[5:3]};
		cfg_prod  = {8'b0, cfg_res} << cfg_shift;
		cfg_sum   = {1'b0, cfg_prod} + 13'd7;
	end

	// Saturating score steps.
	logic [7:0] score_up, score_down;
	assign score_up   = (score_q > 8'd251) ? 8'd255 : score_q + 8'd4;
	assign score_down = (score_q > 8'd0) ? score_q - 8'd1 : 8'd0;

	// Next state and results.
	always_comb begin
		ph_d     = ph_q;
		seq_d    = seq_q;
		sender_d = sender_q;
		resb_d   = resb_q;
		ccount_d = ccount_q;
		route_d  = route_q;
		disc_d   = disc_q;
		bleft_d  = bleft_q;
		xor_d    = xor_q;
		chk_d    = chk_q;
		asm_d    = asm_q;
		pos_d    = pos_q;
		ptr_d    = ptr_q;
		score_d  = score_q;
		res      = '0;
		unique case (ph_q)
			PH_WAIT: begin
				if (data_byte == start_marker) ph_d = PH_SEQ;
			end
			PH_SEQ: begin
				seq_d = data_byte;
				xor_d = data_byte;
				ph_d  = PH_SENDER;
			end
			PH_SENDER: begin
				sender_d = data_byte;
				xor_d    = xor_q ^ data_byte;
				ph_d     = PH_CONFIG;
			end
			PH_CONFIG: begin
				xor_d    = xor_q ^ data_byte;
				resb_d   = cfg_res;
				ccount_d = 9'd1 << cfg_shift;
				route_d  = '0;
				disc_d   = '0;
				bleft_d  = cfg_sum[11:3];
				asm_d    = '0;
				pos_d    = '0;
				ptr_d    = '0;
				ph_d     = data_byte[7] ? PH_MESH : PH_DATA;
			end
			PH_MESH: begin
				xor_d   = xor_q ^ data_byte;
				route_d = data_byte[3:0];
				disc_d  = data_byte[6:5];
				ph_d    = (data_byte[6:5] == DISC_MSG) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				xor_d = xor_q ^ data_byte;
				ptr_d = ptr2;
				if (!c1) begin
					asm_d = wide[11:0];
					pos_d = pos_q + 4'd8;
				end else if (!c2) begin
					asm_d = {4'b0, rest};
					pos_d = rem;
				end else begin
					asm_d = {4'b0, rest2};
					pos_d = rem - resb_q;
				end
				res.count = 2'(e1) + 2'(e2);
				res.r0.kind          = KIND_CHAN;
				res.r0.last          = !e2;
				res.r0.channel_index = ptr_q[7:0];
				res.r0.channel_value = val1;
				res.r1.kind          = KIND_CHAN;
				res.r1.last          = 1'b1;
				res.r1.channel_index = ptr1[7:0];
				res.r1.channel_value = val2;
				if (bleft_q > 9'd0) bleft_d = bleft_q - 9'd1;
				if (bleft_q <= 9'd1) ph_d = PH_CHECK;
			end
			PH_CHECK: begin
				chk_d = (data_byte == xor_q);
				if (data_byte != xor_q) score_d = score_up;
				ph_d = PH_END;
			end
			PH_END: begin
				if (data_byte == end_marker) begin
					score_d     = score_down;
					res.r0.kind = KIND_FRAME_OK;
				end else begin
					score_d     = score_up;
					res.r0.kind = KIND_FRAME_BAD;
				end
				res.count              = 2'd1;
				res.r0.last            = 1'b1;
				res.r0.checksum_ok     = chk_q;
				res.r0.sequence_id     = seq_q;
				res.r0.sender_id       = sender_q;
				res.r0.resolution_bits = resb_q;
				res.r0.channel_count   = ccount_q;
				res.r0.routing_length  = route_q;
				res.r0.discover_state  = disc_q;
				res.r0.error_count     = score_d;
				ph_d = PH_WAIT;
			end
			default: ph_d = PH_WAIT;
		endcase
	end

	// Parser state registers, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_WAIT;
			seq_q    <= '0;
			sender_q <= '0;
			resb_q   <= 4'd12;
			ccount_q <= 9'd1;
			route_q  <= '0;
			disc_q   <= '0;
			bleft_q  <= '0;
			xor_q    <= '0;
			chk_q    <= 1'b0;
			asm_q    <= '0;
			pos_q    <= '0;
			ptr_q    <= '0;
			score_q  <= '0;
		end else if (step) begin
			ph_q     <= ph_d;
			seq_q    <= seq_d;
			sender_q <= sender_d;
			resb_q   <= resb_d;
			ccount_q <= ccount_d;
			route_q  <= route_d;
			disc_q   <= disc_d;
			bleft_q  <= bleft_d;
			xor_q    <= xor_d;
			chk_q    <= chk_d;
			asm_q    <= asm_d;
			pos_q    <= pos_d;
			ptr_q    <= ptr_d;
			score_q  <= score_d;
		end
	end

	// The bit position always stays below the channel width.
	a_pos_below_res: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < resb_q) else $error("bit position reached channel width");

	// The channel pointer never passes the channel count.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= ccount_q) else $error("channel pointer past channel count");

	// Two results per byte only come from channel data.
	a_two_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd2) |-> (ph_q == PH_DATA && res.r0.kind == KIND_CHAN))
		else $error("two results outside data phase");

endmodule

`default_nettype wire

FILE: rtl/core/rcfr_out_buf.sv
// Two-entry result buffer: takes the words of one byte at once and hands
// them out one per handshake. Depends on rcfr_pkg.
`default_nettype none

module rcfr_out_buf
	import rcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire parse_out_t din,
	output logic            space,
	output logic            valid,
	input  wire logic       ready,
	output result_t         head
);

	result_t    slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && ready;
	assign space = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign head  = slot0_q;

	// Word storage: a load replaces the contents, a pop moves the second up.
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= din.r0;
			slot1_q <= din.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= din.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// A load only lands in a buffer that is empty or empties this cycle.
	a_load_space: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
		else $error("load into occupied result buffer");

	// The fill count never exceeds two.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("result buffer overfilled");

	// Taking one word of a full pair leaves the second word in front.
	a_pair_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load && cnt_q == 2'd2) |=> (cnt_q == 2'd1 && head == $past(slot1_q)))
		else $error("second word lost after pop");

endmodule

`default_nettype wire

FILE: rtl/core/rc_frame_receiver_unit.sv
// Top level of the remote-control frame receiver: input byte register,
// marker registers, parser and result buffer.
// Depends on rcfr_pkg, rcfr_if, rcfr_parser and rcfr_out_buf.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    data_byte (8)
//  out_ch    out  valid / ready    result word, kind..error_count (67)
//  cfg       in   cfg_we           cfg_index (8), cfg_wdata (8)
//
// A byte can be accepted every cycle while the output keeps up. It is parsed while
// it sits in the input register; from there its words go into the result buffer.
// A byte that completes two channel values holds the buffer until both words have
// been taken, and the words of the next byte wait until then.
// Reset clears the parser to waiting for a start byte and loads the markers.
// A stalled output backs up into the input register and then into in_ch.ready.
`default_nettype none

module rc_frame_receiver_unit
	import rcfr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rcfr_in_if.sink                   in_ch,
	rcfr_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_wdata
);

	logic [7:0] start_q, end_q;
	logic [7:0] data_s1;
	logic       valid_s1;
	parse_out_t pres;
	logic       space;
	logic       go;
	logic       load;
	result_t    head;

	// Marker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RESET;
			end_q   <= END_MARKER_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_MARKER) start_q <= cfg_wdata;
			if (cfg_index == CFG_END_MARKER) end_q <= cfg_wdata;
		end
	end

	// A byte moves on when it makes no word or the buffer has room.
	assign go   = valid_s1 && ((pres.count == 2'd0) || space);
	assign load = go && (pres.count != 2'd0);
	assign in_ch.ready = !valid_s1 || go;

	// Input byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) data_s1 <= in_ch.data_byte;
	end

	rcfr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (go),
		.data_byte    (data_s1),
		.start_marker (start_q),
		.end_marker   (end_q),
		.res          (pres)
	);

	rcfr_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.din    (pres),
		.space  (space),
		.valid  (out_ch.valid),
		.ready  (out_ch.ready),
		.head   (head)
	);

	// Result word onto the output channel.
	assign out_ch.kind            = head.kind;
	assign out_ch.last            = head.last;
	assign out_ch.channel_index   = head.channel_index;
	assign out_ch.channel_value   = head.channel_value;
	assign out_ch.checksum_ok     = head.checksum_ok;
	assign out_ch.sequence_id     = head.sequence_id;
	assign out_ch.sender_id       = head.sender_id;
	assign out_ch.resolution_bits = head.resolution_bits;
	assign out_ch.channel_count   = head.channel_count;
	assign out_ch.routing_length  = head.routing_length;
	assign out_ch.discover_state  = head.discover_state;
	assign out_ch.error_count     = head.error_count;

endmodule

`default_nettype wire

FILE: sim/rc_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for rc_frame_receiver_unit: feeds packet bytes through the input
// channel, predicts every result word and checks each one as it leaves.
// Depends on rcfr_pkg, rcfr_if and the frame receiver RTL.

module rc_frame_receiver_unit_tb;
	import rcfr_pkg::*;

	// Parser phases of the predictor.
	typedef enum logic [2:0] {
		FRM_WAIT, FRM_SEQ, FRM_SENDER, FRM_CONFIG, FRM_MESH, FRM_DATA, FRM_CHECK, FRM_END
	} frm_phase_t;

	// How the data bytes of a generated frame are filled.
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ONES   = 1;
	localparam int FILL_ZEROS  = 2;

	// Register indexes past the end of the register list.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [7:0]           in_byte   = 8'h00;
	logic                 res_ready = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_START_MARKER;
	logic [7:0]           cfg_wdata = 8'h00;

	rcfr_in_if  in_ch ();
	rcfr_out_if out_ch ();

	assign in_ch.valid     = in_valid;
	assign in_ch.data_byte = in_byte;
	assign out_ch.ready    = res_ready;

	rc_frame_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Marker registers as the receiver should hold them.
	logic [7:0] start_mark = START_MARKER_RESET;
	logic [7:0] end_mark   = END_MARKER_RESET;

	// Deframer state of the predictor.
	frm_phase_t frm_phase   = FRM_WAIT;
	logic [7:0] seq_id      = 8'd0;
	logic [7:0] sender      = 8'd0;
	logic [3:0] res_bits    = 4'd12;
	logic [8:0] chan_total  = 9'd1;
	logic [3:0] route_len   = 4'd0;
	logic [1:0] disc_state  = 2'd0;
	logic [8:0] bytes_to_go = 9'd0;
	logic [7:0] xor_sum     = 8'd0;
	logic       chk_good    = 1'b0;
	logic [11:0] asm_value  = 12'd0;
	logic [3:0] bit_idx     = 4'd0;
	logic [8:0] chan_next   = 9'd0;
	logic [7:0] err_level   = 8'd0;
	logic [7:0] err_peak    = 8'd0;

	logic [7:0] byte_backlog[$];
	result_t    expected_words[$];

	bit calm          = 1'b0;
	int hold_requests = 0;
	int stim_bytes    = 0;
	int bytes_sent    = 0;
	int chan_words    = 0;
	int frame_words   = 0;
	int fail_count    = 0;

	// Work out the result words that one received byte causes.
	function automatic void decode_byte(input logic [7:0] d);
		result_t words[2];
		int n;
		int b;
		n = 0;
		words[0] = '0;
		words[1] = '0;
		case (frm_phase)
			FRM_WAIT: begin
				if (d == start_mark) frm_phase = FRM_SEQ;
			end
			FRM_SEQ: begin
				seq_id = d;
				xor_sum = d;
				frm_phase = FRM_SENDER;
			end
			FRM_SENDER: begin
				sender = d;
				xor_sum ^= d;
				frm_phase = FRM_CONFIG;
			end
			FRM_CONFIG: begin
				xor_sum ^= d;
				res_bits = 4'd5 + 4'(d[2:0]);
				chan_total = (d[5:3] == 3'd7) ? 9'd256 : 9'(1 << d[5:3]);
				route_len = 4'd0;
				disc_state = 2'd0;
				bytes_to_go = 9'((res_bits * chan_total + 7) / 8);
				asm_value = 12'd0;
				bit_idx = 4'd0;
				chan_next = 9'd0;
				frm_phase = d[7] ? FRM_MESH : FRM_DATA;
			end
			FRM_MESH: begin
				xor_sum ^= d;
				route_len = d[3:0];
				disc_state = d[6:5];
				frm_phase = (d[6:5] == 2'd1) ? FRM_CHECK : FRM_DATA;
			end
			FRM_DATA: begin
				// Bits go in LSB first; a channel is emitted once its last bit lands.
				xor_sum ^= d;
				for (b = 0; b < 8; b++) begin
					if (d[b]) asm_value[bit_idx] = 1'b1;
					bit_idx++;
					if (bit_idx >= res_bits) begin
						if (chan_next < chan_total) begin
							if (n < 2) begin
								words[n].kind = KIND_CHAN;
								words[n].channel_index = chan_next[7:0];
								words[n].channel_value = asm_value;
								n++;
							end
							chan_next++;
						end
						asm_value = 12'd0;
						bit_idx = 4'd0;
					end
				end
				if (n > 0) words[n-1].last = 1'b1;
				if (bytes_to_go > 0) bytes_to_go--;
				if (bytes_to_go == 0) frm_phase = FRM_CHECK;
			end
			FRM_CHECK: begin
				chk_good = (d == xor_sum);
				if (!chk_good) err_level = (err_level > 8'd251) ? 8'd255 : err_level + 8'd4;
				frm_phase = FRM_END;
			end
			default: begin
				// End byte: score moves and the frame summary goes out.
				if (d == end_mark) begin
					if (err_level > 0) err_level--;
					words[0].kind = KIND_FRAME_OK;
				end else begin
					err_level = (err_level > 8'd251) ? 8'd255 : err_level + 8'd4;
					words[0].kind = KIND_FRAME_BAD;
				end
				words[0].last = 1'b1;
				words[0].checksum_ok = chk_good;
				words[0].sequence_id = seq_id;
				words[0].sender_id = sender;
				words[0].resolution_bits = res_bits;
				words[0].channel_count = chan_total;
				words[0].routing_length = route_len;
				words[0].discover_state = disc_state;
				words[0].error_count = err_level;
				if (err_level > err_peak) err_peak = err_level;
				n = 1;
				frm_phase = FRM_WAIT;
			end
		endcase
		for (b = 0; b < n; b++) expected_words.push_back(words[b]);
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic void push_byte(input logic [7:0] d);
		byte_backlog.push_back(d);
		stim_bytes++;
	endfunction

	// Queue one whole packet; the checksum and end byte may be spoiled on purpose.
	function automatic void queue_frame(input logic [7:0] seq_b, input logic [7:0] sender_b,
		input logic [7:0] cfg_b, input logic [7:0] mesh_b, input int fill,
		input bit bad_chk, input bit bad_end);
		int nbytes;
		int i;
		logic [7:0] sum;
		logic [7:0] d;
		nbytes = 0;
		if (!(cfg_b[7] && mesh_b[6:5] == 2'd1)) begin
			nbytes = ((5 + cfg_b[2:0]) * ((cfg_b[5:3] == 3'd7) ? 256 : (1 << cfg_b[5:3])) + 7) / 8;
		end
		push_byte(start_mark);
		push_byte(seq_b);
		push_byte(sender_b);
		push_byte(cfg_b);
		sum = seq_b ^ sender_b ^ cfg_b;
		if (cfg_b[7]) begin
			push_byte(mesh_b);
			sum ^= mesh_b;
		end
		for (i = 0; i < nbytes; i++) begin
			d = (fill == FILL_ONES) ? 8'hFF : (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom);
			push_byte(d);
			sum ^= d;
		end
		push_byte(bad_chk ? sum ^ 8'($urandom_range(1, 255)) : sum);
		push_byte(bad_end ? end_mark ^ 8'($urandom_range(1, 255)) : end_mark);
	endfunction

	// A random packet, mostly well formed and mostly with few channels.
	function automatic void queue_random_frame(input bit wide);
		logic [7:0] cfg_b;
		int r;
		cfg_b = 8'($urandom);
		if (wide) begin
			cfg_b[7] = 1'b0;
			cfg_b[5:3] = 3'd7;
			cfg_b[2:0] = 3'($urandom_range(0, 1));
		end else if ($urandom_range(0, 9) == 0) begin
			cfg_b[5:3] = 3'($urandom_range(4, 5));
		end else begin
			cfg_b[5:3] = 3'($urandom_range(0, 3));
		end
		r = $urandom_range(0, 19);
		queue_frame(8'($urandom), 8'($urandom), cfg_b, 8'($urandom), FILL_RANDOM,
			r < 2, r == 2 || r == 3);
		if ($urandom_range(0, 3) == 0) push_byte(8'($urandom));
	endfunction

	function automatic void queue_random_frames(input int budget);
		int goal;
		goal = stim_bytes + budget;
		while (stim_bytes < goal) queue_random_frame(1'b0);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_START_MARKER) start_mark = val;
		else if (idx == CFG_END_MARKER) end_mark = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every byte is in and every predicted word has come out.
	task automatic settle();
		do @(negedge clk);
		while (byte_backlog.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_word();
		result_t want;
		if (expected_words.size() == 0) begin
			$error("result word with none expected, kind %0d", out_ch.kind);
			fail_count++;
		end else begin
			want = expected_words.pop_front();
			compare_field("kind", want.kind, out_ch.kind);
			compare_field("last", want.last, out_ch.last);
			compare_field("channel_index", want.channel_index, out_ch.channel_index);
			compare_field("channel_value", want.channel_value, out_ch.channel_value);
			compare_field("checksum_ok", want.checksum_ok, out_ch.checksum_ok);
			compare_field("sequence_id", want.sequence_id, out_ch.sequence_id);
			compare_field("sender_id", want.sender_id, out_ch.sender_id);
			compare_field("resolution_bits", want.resolution_bits, out_ch.resolution_bits);
			compare_field("channel_count", want.channel_count, out_ch.channel_count);
			compare_field("routing_length", want.routing_length, out_ch.routing_length);
			compare_field("discover_state", want.discover_state, out_ch.discover_state);
			compare_field("error_count", want.error_count, out_ch.error_count);
			if (want.kind == KIND_CHAN) chan_words++;
			else frame_words++;
		end
	endtask

	// Byte driver: offers the next byte after a random gap.
	int send_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			send_wait = 0;
		end else begin
			if (in_valid && in_ch.ready) begin
				decode_byte(in_byte);
				bytes_sent++;
			end
			if (!in_valid || in_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (byte_backlog.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= byte_backlog.pop_front();
					send_wait = draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each word and stalls at random or for a long hold.
	int recv_wait   = 0;
	int hold_left   = 0;
	int hold_served = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (out_ch.valid && res_ready) begin
				check_word();
				recv_wait = draw_gap();
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: noise while waiting, widest resolution with padding, a bad
		// discover message with config bit six set, and a frame whose header
		// holds the marker values and whose data byte completes two channels.
		push_byte(8'h00);
		push_byte(8'hFF);
		queue_frame(8'hFF, 8'h00, 8'h07, 8'h00, FILL_ONES, 1'b0, 1'b0);
		queue_frame(8'h00, 8'hFF, 8'hC0, 8'hAF, FILL_RANDOM, 1'b1, 1'b1);
		queue_frame(start_mark, end_mark, 8'h90, 8'hC0, FILL_RANDOM, 1'b0, 1'b0);
		settle();

		// Lowest start marker, highest end marker, random idling.
		write_reg(CFG_START_MARKER, 8'h00);
		write_reg(CFG_END_MARKER, 8'hFF);
		write_reg(CFG_UNUSED_LOW, 8'($urandom));
		end_writes();
		queue_random_frames(80);
		settle();

		// Opposite extremes; a burst of bad discover messages drives the score
		// into saturation with no idling on either side.
		write_reg(CFG_START_MARKER, 8'hFF);
		write_reg(CFG_END_MARKER, 8'h00);
		write_reg(CFG_UNUSED_TOP, 8'($urandom));
		end_writes();
		calm = 1'b1;
		repeat (34) begin
			logic [7:0] mesh_b;
			mesh_b = 8'($urandom);
			mesh_b[6:5] = 2'd1;
			queue_frame(8'($urandom), 8'($urandom), 8'($urandom) | 8'h80, mesh_b,
				FILL_RANDOM, 1'b1, 1'b1);
		end
		settle();
		calm = 1'b0;

		// Random markers; the receiver holds off while a full-size frame comes in.
		write_reg(CFG_START_MARKER, 8'($urandom));
		write_reg(CFG_END_MARKER, 8'($urandom));
		end_writes();
		hold_requests++;
		queue_random_frame(1'b1);
		queue_random_frames(60);
		settle();

		// Reset values again, ending with a frame cut short before its end byte.
		write_reg(CFG_START_MARKER, START_MARKER_RESET);
		write_reg(CFG_END_MARKER, END_MARKER_RESET);
		end_writes();
		queue_random_frames(60);
		queue_frame(8'($urandom), 8'($urandom), 8'h0B, 8'h00, FILL_RANDOM, 1'b0, 1'b0);
		void'(byte_backlog.pop_back());
		settle();

		// The end marker changes while the frame waits for its end byte.
		write_reg(CFG_END_MARKER, 8'($urandom));
		end_writes();
		push_byte(end_mark);
		settle();

		$display("Sent %0d bytes; checked %0d channel words and %0d frame results.",
			bytes_sent, chan_words, frame_words);
		$display("Five marker settings, one long output hold; error score peaked at %0d.",
			err_peak);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
